@@ src/particle_pool_euler_step_core_assert.svh @@
`ifndef PARTICLE_POOL_EULER_STEP_CORE_ASSERT_SVH
`define PARTICLE_POOL_EULER_STEP_CORE_ASSERT_SVH
// Assertion helpers; they expect signals named clk and rst in scope.
`define PPE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PPE_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/ppe_pkg.sv @@
`timescale 1ns / 1ps
package ppe_pkg;

  localparam logic [1:0] KIND_SPAWN_OK   = 2'd0;
  localparam logic [1:0] KIND_SPAWN_FULL = 2'd1;
  localparam logic [1:0] KIND_PARTICLE   = 2'd2;
  localparam logic [1:0] KIND_EMPTY_TICK = 2'd3;

  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [30:0]        life;
    logic [15:0]        size;
  } particle_t;

  typedef struct packed {
    logic        tick;
    logic [23:0] dt;
    particle_t   p;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        size;
  } result_t;

endpackage

@@ src/ppe_front.sv @@
`timescale 1ns / 1ps
module ppe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ppe_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output ppe_pkg::cmd_t cmd
);

  // Two-entry queue; the head is always entry 0.
  ppe_pkg::cmd_t q0;
  ppe_pkg::cmd_t q1;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q0;
  assign do_push   = push && !full;
  assign do_pop    = cmd_ready && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_pop) begin
      if (do_push && count == 2'd1) begin
        q0 <= in_cmd;
      end else begin
        q0 <= q1;
      end
    end else if (do_push && count == 2'd0) begin
      q0 <= in_cmd;
    end
    if (do_push && count != 2'd0 && !(count == 2'd1 && do_pop)) begin
      q1 <= in_cmd;
    end
  end

endmodule

@@ src/ppe_engine.sv @@
`timescale 1ns / 1ps
module ppe_engine #(
  parameter int POOL_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ppe_pkg::cmd_t      cmd,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_size,
  output logic [5:0]         live_count,
  output logic               last
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SPAWN_PUT, S_RD, S_WAIT, S_EVAL, S_MUL, S_ADD, S_WR,
    S_EMPTY_PUT, S_DR_RD, S_DR_WAIT, S_DR_PUT
  } state_t;

  state_t             state;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      rcnt;
  logic [CW-1:0]      dr;
  logic [23:0]        dt;
  logic [1:0]         op;
  logic               spawn_full;
  ppe_pkg::particle_t cur;
  logic signed [56:0] prod;
  logic               ovalid;

  ppe_pkg::particle_t pool_mem [POOL_DEPTH];
  ppe_pkg::particle_t pool_q;
  ppe_pkg::result_t   rbuf [POOL_DEPTH];
  ppe_pkg::result_t   rbuf_q;

  logic               pool_re;
  logic [AW-1:0]      pool_ra;
  logic               pool_we;
  logic [AW-1:0]      pool_wa;
  ppe_pkg::particle_t pool_wd;

  logic               ofree;
  logic               out_load;
  logic [CW-1:0]      lastslot;
  logic signed [31:0] mop;
  logic signed [31:0] base;
  logic signed [41:0] sum;
  logic signed [31:0] sat;

  assign empty     = !ovalid;
  assign ofree     = !ovalid || pop;
  assign out_load  = ofree && (state == S_SPAWN_PUT || state == S_EMPTY_PUT ||
                               state == S_DR_PUT);
  assign cmd_ready = (state == S_IDLE);
  assign lastslot  = cnt - CW'(1);

  always_comb begin
    pool_re = 1'b0;
    pool_ra = idx[AW-1:0];
    if (state == S_RD && idx < cnt) begin
      pool_re = 1'b1;
    end else if (state == S_EVAL && cur.life <= 31'(dt) && idx < lastslot) begin
      pool_re = 1'b1;
      pool_ra = lastslot[AW-1:0];
    end
    pool_we = 1'b0;
    pool_wa = idx[AW-1:0];
    pool_wd = cur;
    if (state == S_IDLE && cmd_valid && cmd.tick == ppe_pkg::OP_SPAWN &&
        cnt < DEPTH_C) begin
      pool_we = 1'b1;
      pool_wa = cnt[AW-1:0];
      pool_wd = cmd.p;
    end else if (state == S_WR) begin
      pool_we = 1'b1;
    end
  end

  always_comb begin
    unique case (op)
      2'd0:    begin mop = cur.acc_x; base = cur.vel_x; end
      2'd1:    begin mop = cur.acc_y; base = cur.vel_y; end
      2'd2:    begin mop = cur.vel_x; base = cur.pos_x; end
      default: begin mop = cur.vel_y; base = cur.pos_y; end
    endcase
    // Arithmetic shift floors the Q.32 product back to Q16.16.
    sum = 42'(base) + 42'(prod >>> 16);
    if (sum > 42'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -42'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (pool_re) begin
      pool_q <= pool_mem[pool_ra];
    end
    if (state == S_WR) begin
      rbuf[rcnt[AW-1:0]] <= '{pos_x: cur.pos_x, pos_y: cur.pos_y, size: cur.size};
    end
    if (state == S_DR_RD) begin
      rbuf_q <= rbuf[dr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ovalid <= 1'b0;
      idx    <= '0;
      rcnt   <= '0;
      dr     <= '0;
      op     <= 2'd0;
    end else begin
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.tick == ppe_pkg::OP_SPAWN) begin
              spawn_full <= (cnt >= DEPTH_C);
              if (cnt < DEPTH_C) begin
                cnt <= cnt + CW'(1);
              end
              state <= S_SPAWN_PUT;
            end else begin
              dt    <= cmd.dt;
              idx   <= '0;
              rcnt  <= '0;
              state <= S_RD;
            end
          end
        end
        S_SPAWN_PUT: begin
          if (ofree) begin
            kind       <= spawn_full ? ppe_pkg::KIND_SPAWN_FULL : ppe_pkg::KIND_SPAWN_OK;
            out_pos_x  <= '0;
            out_pos_y  <= '0;
            out_size   <= '0;
            live_count <= 6'(cnt);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_RD: begin
          if (idx < cnt) begin
            state <= S_WAIT;
          end else if (rcnt == '0) begin
            state <= S_EMPTY_PUT;
          end else begin
            dr    <= '0;
            state <= S_DR_RD;
          end
        end
        S_WAIT: begin
          cur   <= pool_q;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur.life <= 31'(dt)) begin
            cnt   <= lastslot;
            state <= (idx < lastslot) ? S_WAIT : S_RD;
          end else begin
            cur.life <= cur.life - 31'(dt);
            op       <= 2'd0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mop * $signed({1'b0, dt});
          state <= S_ADD;
        end
        S_ADD: begin
          unique case (op)
            2'd0:    cur.vel_x <= sat;
            2'd1:    cur.vel_y <= sat;
            2'd2:    cur.pos_x <= sat;
            default: cur.pos_y <= sat;
          endcase
          op    <= op + 2'd1;
          state <= (op == 2'd3) ? S_WR : S_MUL;
        end
        S_WR: begin
          rcnt  <= rcnt + CW'(1);
          idx   <= idx + CW'(1);
          state <= S_RD;
        end
        S_EMPTY_PUT: begin
          if (ofree) begin
            kind       <= ppe_pkg::KIND_EMPTY_TICK;
            out_pos_x  <= '0;
            out_pos_y  <= '0;
            out_size   <= '0;
            live_count <= 6'(cnt);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DR_RD: begin
          state <= S_DR_WAIT;
        end
        S_DR_WAIT: begin
          state <= S_DR_PUT;
        end
        S_DR_PUT: begin
          if (ofree) begin
            kind       <= ppe_pkg::KIND_PARTICLE;
            out_pos_x  <= rbuf_q.pos_x;
            out_pos_y  <= rbuf_q.pos_y;
            out_size   <= rbuf_q.size;
            live_count <= 6'(cnt);
            last       <= (dr == rcnt - CW'(1));
            dr         <= dr + CW'(1);
            state      <= (dr == rcnt - CW'(1)) ? S_IDLE : S_DR_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/particle_pool_euler_step_core.sv @@
`timescale 1ns / 1ps
// Particle pool with fixed-point explicit Euler motion.
// Input channel: push/full. A transfer carries an opcode (spawn or tick),
// the tick time step and the spawn fields. A two-entry queue in front lets
// the next items enter while the engine is busy with the current one.
// Result channel: empty/pop. The oldest result is on the ports while empty
// is low; every result of an item carries the live count after that item,
// and the final result of the item has last set.
// A spawn gives its single result. A tick steps the surviving particles one at
// a time, limited by the one pool memory read port and the single shared
// 32x25 multiplier that does the four Euler products in turn; their results
// are then drained from a result buffer once all particles are done, and
// removed particles give no result. A tick with no survivors, as on an empty
// pool, gives a single empty-tick result.
// Reset empties the pool and both queues; pool contents are not cleared.
// When the receiver holds pop low, the result stays on the ports, the engine
// waits, and full rises once the input queue has filled.
module particle_pool_euler_step_core #(
  parameter int POOL_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [23:0]        delta_time,
  input  logic signed [31:0] spawn_pos_x,
  input  logic signed [31:0] spawn_pos_y,
  input  logic signed [31:0] spawn_vel_x,
  input  logic signed [31:0] spawn_vel_y,
  input  logic signed [31:0] spawn_acc_x,
  input  logic signed [31:0] spawn_acc_y,
  input  logic [30:0]        spawn_lifetime,
  input  logic [15:0]        spawn_size,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_size,
  output logic [5:0]         live_count,
  output logic               last
);

  ppe_pkg::cmd_t in_cmd;
  ppe_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  // Pack the input fields into one command word for the queue.
  assign in_cmd = '{tick: opcode, dt: delta_time,
                    p: '{pos_x: spawn_pos_x, pos_y: spawn_pos_y,
                         vel_x: spawn_vel_x, vel_y: spawn_vel_y,
                         acc_x: spawn_acc_x, acc_y: spawn_acc_y,
                         life: spawn_lifetime, size: spawn_size}};

  ppe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ppe_engine #(.POOL_DEPTH(POOL_DEPTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_size   (out_size),
    .live_count (live_count),
    .last       (last)
  );

endmodule

@@ src/ppe_checker.sv @@
`timescale 1ns / 1ps
`include "particle_pool_euler_step_core_assert.svh"
module ppe_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input logic [1:0]        kind,
  input logic signed [31:0] out_pos_x,
  input logic [5:0]        live_count,
  input logic              last
);

  `PPE_ASSERT_NXT(a_hold, !empty && !pop, !empty)
  `PPE_ASSERT_IMP(a_empty_tick, !empty && kind == ppe_pkg::KIND_EMPTY_TICK, last && live_count == 6'd0)
  `PPE_ASSERT_IMP(a_spawn_last, !empty && kind != ppe_pkg::KIND_PARTICLE, last)
  `PPE_ASSERT_IMP(a_spawn_zero, !empty && kind == ppe_pkg::KIND_SPAWN_OK, out_pos_x == 32'sd0)

endmodule

bind particle_pool_euler_step_core ppe_checker u_ppe_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .kind       (kind),
  .out_pos_x  (out_pos_x),
  .live_count (live_count),
  .last       (last)
);

@@ test/tb_particle_pool_euler_step_core.sv @@
`timescale 1ns / 1ps
// Checks the particle pool against a behavioral copy of the pool that lives in
// this bench. Every accepted input transfer updates the copy and queues the
// results it must cause; the monitor compares each popped result with the
// oldest queued one.
module tb_particle_pool_euler_step_core;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 1500000;

  // One input transfer as the bench sees it.
  typedef struct packed {
    logic               op;
    logic [23:0]        dt;
    ppe_pkg::particle_t p;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        size;
    logic [5:0]         count;
    logic               last;
  } outcome_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic opcode;
  logic [23:0] delta_time;
  logic signed [31:0] spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y;
  logic signed [31:0] spawn_acc_x, spawn_acc_y;
  logic [30:0] spawn_lifetime;
  logic [15:0] spawn_size;
  logic empty;
  logic pop;
  logic [1:0] kind;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [15:0] out_size;
  logic [5:0] live_count;
  logic last;

  particle_pool_euler_step_core #(.POOL_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .delta_time(delta_time), .spawn_pos_x(spawn_pos_x), .spawn_pos_y(spawn_pos_y),
    .spawn_vel_x(spawn_vel_x), .spawn_vel_y(spawn_vel_y),
    .spawn_acc_x(spawn_acc_x), .spawn_acc_y(spawn_acc_y),
    .spawn_lifetime(spawn_lifetime), .spawn_size(spawn_size),
    .empty(empty), .pop(pop), .kind(kind), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_size(out_size), .live_count(live_count),
    .last(last)
  );

  item_t    pending_items[$];
  outcome_t expected_outcomes[$];

  // The bench's own copy of the pool.
  ppe_pkg::particle_t pool[DEPTH];
  int                 pool_count = 0;

  int  errors = 0;
  int  cycles = 0;
  int  pops_seen = 0;
  // Knobs that the sequence in the initial block turns.
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  int  hold_len = 0;     // length of the long receiver hold-off, once set
  bit  send_pause = 1'b0; // sender offers nothing while set
  // State of the hold-off counter.
  int  hold_left;
  bit  hold_taken;
  // Mirrors what the driver has put on the pins, so the driver never has to
  // read back its own nonblocking assignments.
  bit  offering = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Product of a rate and the time step, floored back to Q16.16, added to the
  // base and saturated to 32 bits.
  function automatic logic signed [31:0] euler_advance(logic signed [31:0] base,
                                                       logic signed [31:0] rate,
                                                       logic [23:0] dt);
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    prod = 64'(rate) * $signed({40'd0, dt});
    sum = 64'(base) + (prod >>> 16);
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  // Applies one accepted item to the pool copy and queues its results.
  task automatic predict_pool_item(item_t it);
    outcome_t res[$];
    outcome_t r;
    logic signed [32:0] life;
    int i;
    int tail;
    if (it.op == ppe_pkg::OP_SPAWN) begin
      r = '0;
      if (pool_count >= DEPTH) begin
        r.kind = ppe_pkg::KIND_SPAWN_FULL;
      end else begin
        pool[pool_count] = it.p;
        pool_count++;
        r.kind = ppe_pkg::KIND_SPAWN_OK;
      end
      res = {res, r};
    end else begin
      i = 0;
      while (i < pool_count) begin
        life = $signed({2'b00, pool[i].life}) - $signed({9'd0, it.dt});
        if (life <= 0) begin
          // The tail particle takes the freed slot and is handled there.
          tail = pool_count - 1;
          if (i < tail) pool[i] = pool[tail];
          pool_count = tail;
        end else begin
          pool[i].life = life[30:0];
          pool[i].vel_x = euler_advance(pool[i].vel_x, pool[i].acc_x, it.dt);
          pool[i].vel_y = euler_advance(pool[i].vel_y, pool[i].acc_y, it.dt);
          pool[i].pos_x = euler_advance(pool[i].pos_x, pool[i].vel_x, it.dt);
          pool[i].pos_y = euler_advance(pool[i].pos_y, pool[i].vel_y, it.dt);
          r = '0;
          r.kind = ppe_pkg::KIND_PARTICLE;
          r.px = pool[i].pos_x;
          r.py = pool[i].pos_y;
          r.size = pool[i].size;
          res = {res, r};
          i++;
        end
      end
      if (res.size() == 0) begin
        r = '0;
        r.kind = ppe_pkg::KIND_EMPTY_TICK;
        res = {res, r};
      end
    end
    foreach (res[k]) begin
      res[k].count = 6'(pool_count);
      res[k].last = (k == res.size() - 1);
      expected_outcomes = {expected_outcomes, res[k]};
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s at result %0d: got %h want %h", what, pops_seen, got, want);
    errors++;
  endtask

  task automatic add_item(item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 65535 * 8))) - 32'sd262144;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic item_t make_spawn(logic [30:0] life);
    item_t it;
    it.op = ppe_pkg::OP_SPAWN;
    it.dt = 24'($urandom());
    it.p.pos_x = rand_word();
    it.p.pos_y = rand_word();
    it.p.vel_x = rand_word();
    it.p.vel_y = rand_word();
    it.p.acc_x = rand_word();
    it.p.acc_y = rand_word();
    it.p.life = life;
    it.p.size = 16'($urandom());
    return it;
  endfunction

  function automatic item_t make_tick(logic [23:0] dt);
    item_t it;
    it = make_spawn(31'($urandom()));
    it.op = ppe_pkg::OP_TICK;
    it.dt = dt;
    return it;
  endfunction

  // Lifetimes are mostly a few ticks long so that removals happen often.
  function automatic logic [30:0] rand_life();
    case ($urandom_range(0, 9))
      0: return 31'h7fffffff;
      1: return '0;
      2: return 31'($urandom());
      default: return 31'($urandom_range(1, 6 * 65536));
    endcase
  endfunction

  function automatic logic [23:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 24'hffffff;
      1: return '0;
      2: return 24'($urandom());
      default: return 24'($urandom_range(1, 65536 * 2));
    endcase
  endfunction

  // Driver: holds an item on the pins until a transfer takes it, then loads
  // the next one or idles. Each pin is assigned at most once per edge.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      opcode <= ppe_pkg::OP_SPAWN;
      delta_time <= '0;
      spawn_pos_x <= '0;
      spawn_pos_y <= '0;
      spawn_vel_x <= '0;
      spawn_vel_y <= '0;
      spawn_acc_x <= '0;
      spawn_acc_y <= '0;
      spawn_lifetime <= '0;
      spawn_size <= '0;
      offering = 1'b0;
    end else begin
      if (offering && !full) begin
        predict_pool_item(pending_items.pop_front());
        offering = 1'b0;
      end
      if (!offering && pending_items.size() > 0 && !send_pause &&
          !(send_idle_en && $urandom_range(0, 99) < 27)) begin
        opcode <= pending_items[0].op;
        delta_time <= pending_items[0].dt;
        spawn_pos_x <= pending_items[0].p.pos_x;
        spawn_pos_y <= pending_items[0].p.pos_y;
        spawn_vel_x <= pending_items[0].p.vel_x;
        spawn_vel_y <= pending_items[0].p.vel_y;
        spawn_acc_x <= pending_items[0].p.acc_x;
        spawn_acc_y <= pending_items[0].p.acc_y;
        spawn_lifetime <= pending_items[0].p.life;
        spawn_size <= pending_items[0].p.size;
        offering = 1'b1;
      end
      push <= offering;
    end
  end

  // Long receiver hold-off, counted down once it has been requested.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (!hold_taken && hold_len > 0) begin
      hold_left <= hold_len;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks a result when it transfers, then picks pop for the next
  // edge.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result kind", kind, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
          if (out_pos_x !== want.px) report_mismatch("out_pos_x", out_pos_x, want.px);
          if (out_pos_y !== want.py) report_mismatch("out_pos_y", out_pos_y, want.py);
          if (out_size !== want.size) report_mismatch("out_size", out_size, want.size);
          if (live_count !== want.count)
            report_mismatch("live_count", live_count, want.count);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
        pops_seen++;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= !(recv_idle_en && $urandom_range(0, 99) < 27);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || offering || expected_outcomes.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    item_t it;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a tick on an empty pool, saturating particles at both
    // extremes, a zero-lifetime spawn, and ticks with the largest and smallest steps.
    add_item(make_tick(24'h010000));
    it = make_spawn(31'h7fffffff);
    it.p.pos_x = 32'sh7fffffff; it.p.vel_x = 32'sh7fffffff; it.p.acc_x = 32'sh7fffffff;
    it.p.pos_y = 32'sh80000000; it.p.vel_y = 32'sh80000000; it.p.acc_y = 32'sh80000000;
    it.p.size = 16'hffff;
    add_item(it);
    it.p.pos_x = 32'sh80000000; it.p.vel_x = 32'sh80000000; it.p.acc_x = 32'sh80000000;
    it.p.pos_y = 32'sh7fffffff; it.p.vel_y = 32'sh7fffffff; it.p.acc_y = 32'sh7fffffff;
    it.p.size = 16'h0000;
    add_item(it);
    add_item(make_spawn(31'd0));
    it = make_spawn(31'd3);
    it.p.pos_x = -32'sd3; it.p.vel_x = -32'sd1; it.p.acc_x = 32'sd0;
    add_item(it);
    add_item(make_tick(24'hffffff));
    add_item(make_tick(24'd0));
    add_item(make_tick(24'd1));
    add_item(make_tick(24'd2));
    // Fill the pool past its depth so that spawns are rejected.
    repeat (DEPTH + 2) add_item(make_spawn(rand_life()));
    add_item(make_tick(rand_dt()));
    add_item(make_tick(24'hffffff));
    add_item(make_tick(24'hffffff));
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block backs up and raises full.
    hold_len = 600;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) add_item(make_tick(rand_dt()));
      else add_item(make_spawn(rand_life()));
    end
    wait_drained();

    // Random part: a random mix of spawns and ticks, mostly realistic.
    for (int n = 0; n < 334; n++) begin
      if (n == 120) begin
        // A stretch with no idling on either side.
        wait_drained();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end
      if (n == 200) begin
        wait_drained();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
      end
      if (n == 260) begin
        // The sender pauses until every result has come back.
        send_pause = 1'b1;
        while (offering || expected_outcomes.size() > 0) @(posedge clk);
        send_pause = 1'b0;
      end
      if ($urandom_range(0, 99) < 60) add_item(make_spawn(rand_life()));
      else add_item(make_tick(rand_dt()));
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
